// File: hdl/utf8_to_utf16_transcoder_assert.svh
// assertion macros shared by the transcoder
`ifndef UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH
`define UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH

// condition implies consequence in the same cycle
`define U2U_ASSERT_SAME(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("u2u assertion failed");

// condition implies consequence in the next cycle
`define U2U_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("u2u assertion failed");

`endif

// File: hdl/u2u_pkg.sv
package u2u_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       text_end;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        replaced;
        logic        run_last;
        logic        text_done;
    } t_out_beat;

    localparam int unsigned MAX_UNITS = 4;

    // all the units one input byte causes
    typedef struct packed {
        logic [2:0]                      count;
        t_out_beat [MAX_UNITS-1:0]       units;
    } t_burst;

    localparam logic [15:0] REPL_CHAR   = 16'hFFFD;
    localparam logic [15:0] HI_SURR     = 16'hD800;
    localparam logic [15:0] LO_SURR     = 16'hDC00;
    localparam logic [20:0] CP_MAX      = 21'h10FFFF;
    localparam logic [20:0] SURR_FIRST  = 21'h00D800;
    localparam logic [20:0] SURR_LAST   = 21'h00DFFF;
    localparam logic [20:0] MIN_TWO     = 21'h000080;
    localparam logic [20:0] MIN_THREE   = 21'h000800;
    localparam logic [20:0] ASTRAL_BASE = 21'h010000;

endpackage

// File: hdl/u2u_decode.sv
module u2u_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  u2u_pkg::t_in_beat   i_beat,
    output u2u_pkg::t_burst     o_burst
);

    logic [1:0]  r_expected, n_expected;
    logic [1:0]  r_held, n_held;
    logic [20:0] r_partial, n_partial;

    logic [20:0] acc;
    logic [20:0] lowest;
    logic [20:0] offs;
    logic [2:0]  total;
    logic [2:0]  last_idx;
    logic        start_now;
    logic        bad_seq;
    logic [7:0]  b;
    u2u_pkg::t_burst burst;

    function automatic u2u_pkg::t_burst push(u2u_pkg::t_burst bst, logic [15:0] cu,
                                              logic repl);
        u2u_pkg::t_burst res;
        res = bst;
        res.units[bst.count[1:0]] = '{code_unit: cu, replaced: repl,
                                      run_last: 1'b0, text_done: 1'b0};
        res.count = bst.count + 3'd1;
        return res;
    endfunction

    always_comb begin
        b          = i_beat.in_byte;
        n_expected = r_expected;
        n_held     = r_held;
        n_partial  = r_partial;
        burst      = '0;
        start_now  = 1'b0;
        acc        = {r_partial[14:0], b[5:0]};
        total      = {1'b0, r_held} + 3'd1;
        offs       = acc - u2u_pkg::ASTRAL_BASE;
        case (total)
            3'd2:    lowest = u2u_pkg::MIN_TWO;
            3'd3:    lowest = u2u_pkg::MIN_THREE;
            default: lowest = u2u_pkg::ASTRAL_BASE;
        endcase
        bad_seq = (acc < lowest) || (acc > u2u_pkg::CP_MAX) ||
                  ((acc >= u2u_pkg::SURR_FIRST) && (acc <= u2u_pkg::SURR_LAST));

        if (r_expected != 2'd0) begin
            if (b[7:6] == 2'b10) begin
                if (r_expected == 2'd1) begin
                    if (bad_seq) begin
                        // one replacement per byte of the sequence, this one too
                        for (int i = 0; i < 4; i++) begin
                            if (3'(i) < total) begin
                                burst = push(burst, u2u_pkg::REPL_CHAR, 1'b1);
                            end
                        end
                    end else if (acc < u2u_pkg::ASTRAL_BASE) begin
                        burst = push(burst, acc[15:0], 1'b0);
                    end else begin
                        burst = push(burst, u2u_pkg::HI_SURR + {6'd0, offs[19:10]}, 1'b0);
                        burst = push(burst, u2u_pkg::LO_SURR + {6'd0, offs[9:0]}, 1'b0);
                    end
                    n_expected = 2'd0;
                    n_held     = 2'd0;
                    n_partial  = '0;
                end else begin
                    n_expected = r_expected - 2'd1;
                    n_held     = r_held + 2'd1;
                    n_partial  = acc;
                end
            end else begin
                // broken sequence: flush what is held, then decode this byte afresh
                for (int i = 0; i < 3; i++) begin
                    if (2'(i) < r_held) begin
                        burst = push(burst, u2u_pkg::REPL_CHAR, 1'b1);
                    end
                end
                n_expected = 2'd0;
                n_held     = 2'd0;
                n_partial  = '0;
                start_now  = 1'b1;
            end
        end else begin
            start_now = 1'b1;
        end

        if (start_now) begin
            if (!b[7]) begin
                burst = push(burst, {8'd0, b}, 1'b0);
            end else if (b[7:5] == 3'b110) begin
                n_expected = 2'd1;
                n_held     = 2'd1;
                n_partial  = {16'd0, b[4:0]};
            end else if (b[7:4] == 4'b1110) begin
                n_expected = 2'd2;
                n_held     = 2'd1;
                n_partial  = {17'd0, b[3:0]};
            end else if (b[7:3] == 5'b11110) begin
                n_expected = 2'd3;
                n_held     = 2'd1;
                n_partial  = {18'd0, b[2:0]};
            end else begin
                burst = push(burst, u2u_pkg::REPL_CHAR, 1'b1);
            end
        end

        // end of text with a sequence still open
        if (i_beat.text_end && (n_expected != 2'd0)) begin
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < n_held) begin
                    burst = push(burst, u2u_pkg::REPL_CHAR, 1'b1);
                end
            end
            n_expected = 2'd0;
            n_held     = 2'd0;
            n_partial  = '0;
        end

        last_idx = burst.count - 3'd1;
        if (burst.count != 3'd0) begin
            burst.units[last_idx[1:0]].run_last  = 1'b1;
            burst.units[last_idx[1:0]].text_done = i_beat.text_end;
        end
    end

    assign o_burst = burst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected <= 2'd0;
            r_held     <= 2'd0;
            r_partial  <= '0;
        end else if (i_load) begin
            r_expected <= n_expected;
            r_held     <= n_held;
            r_partial  <= n_partial;
        end
    end

endmodule

// File: hdl/u2u_burst.sv
module u2u_burst (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  u2u_pkg::t_burst     i_burst,
    output logic                o_ready,
    output logic                o_valid,
    output u2u_pkg::t_out_beat  o_data,
    input  logic                i_stall
);

    u2u_pkg::t_out_beat [u2u_pkg::MAX_UNITS-1:0] r_units;
    logic [2:0] r_count;
    logic [1:0] r_idx;
    logic       last;

    assign o_valid = (r_count != 3'd0);
    assign o_data  = r_units[r_idx];
    assign last    = (({1'b0, r_idx} + 3'd1) == r_count);
    // free when it holds nothing, or once the final unit of the held burst goes this cycle
    assign o_ready = !o_valid || (!i_stall && last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 3'd0;
            r_idx   <= 2'd0;
        end else if (i_load) begin
            r_count <= i_burst.count;
            r_idx   <= 2'd0;
        end else if (o_valid && !i_stall) begin
            if (last) begin
                r_count <= 3'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_units <= i_burst.units;
        end
    end

endmodule

// File: hdl/utf8_to_utf16_transcoder.sv
// utf-8 to utf-16 transcoder: takes one utf-8 byte per input beat (with an
// end-of-text flag) and gives utf-16 code units, one per output beat. a
// byte is decoded in the cycle it is accepted and all the units it causes
// (none to four) land together in a burst register; the burst then drains
// one unit per output beat. plain text runs at one byte per cycle while
// the code unit side does not stall; a byte that causes several units holds
// the byte side off until the last of them leaves the burst register.
// astral code points give a surrogate pair; malformed input gives u+fffd,
// one per byte that the failed sequence held. a new byte is taken in the
// same cycle as the last unit of a burst leaves.

`include "utf8_to_utf16_transcoder_assert.svh"

module utf8_to_utf16_transcoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // byte side
    input  logic                i_valid,
    input  u2u_pkg::t_in_beat   i_data,
    output logic                o_stall,
    // code unit side
    output logic                o_valid,
    output u2u_pkg::t_out_beat  o_data,
    input  logic                i_stall
);

    logic            load;
    logic            burst_ready;
    u2u_pkg::t_burst d_burst;

    // input beat accepted whenever the burst register is free or emptying
    assign o_stall = !burst_ready;
    assign load    = i_valid && burst_ready;

    // decoder: sequence state plus the per-byte unit list
    u2u_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_beat  (i_data),
        .o_burst (d_burst)
    );

    // burst register: drains one unit per output beat
    u2u_burst u_burst (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_burst (d_burst),
        .o_ready (burst_ready),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    // the end of the text always yields at least one unit
    `U2U_ASSERT_SAME(a_end_unit, i_clk, i_rst_n, load && i_data.text_end, d_burst.count != 3'd0)
    // never more units than the burst register holds
    `U2U_ASSERT_SAME(a_burst_fits, i_clk, i_rst_n, load, d_burst.count <= 3'd4)
    // text_done only ever marks the last unit of a byte
    `U2U_ASSERT_SAME(a_done_is_last, i_clk, i_rst_n, o_valid && o_data.text_done, o_data.run_last)
    // mid-burst the byte side must be held off
    `U2U_ASSERT_SAME(a_hold_mid_burst, i_clk, i_rst_n, o_valid && !o_data.run_last, o_stall)
    // a unit that is not the last of its byte is followed by another
    `U2U_ASSERT_NEXT(a_burst_on, i_clk, i_rst_n, o_valid && !i_stall && !o_data.run_last, o_valid)

endmodule
